// ===== rtl/tms_pkg.sv =====
`default_nettype none
package tms_pkg;

  // Input operation codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_LOAD      = 3'd1;
  localparam logic [2:0] OP_START_MEL = 3'd2;
  localparam logic [2:0] OP_START_TON = 3'd3;
  localparam logic [2:0] OP_STOP      = 3'd4;

  // Playback phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SOUND = 2'd1;
  localparam logic [1:0] PH_REST  = 2'd2;
  localparam logic [1:0] PH_GAP   = 2'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LOOP_EN  = 2'd0;
  localparam logic [1:0] REG_LOOP_GAP = 2'd1;
  localparam logic [1:0] REG_NOTE_CNT = 2'd2;

  // Timing and frequency limits
  localparam logic [15:0] FREQ_MIN      = 16'd50;
  localparam logic [15:0] FREQ_MAX      = 16'd10000;
  localparam logic [15:0] TONE_DUR_MAX  = 16'd3000;
  localparam logic [15:0] SHORT_NOTE_MS = 16'd20;
  localparam logic [15:0] REST_MS       = 16'd15;
  localparam logic [15:0] LOOP_GAP_RST  = 16'd3000;

  // One stored note: clamped frequency and duration in ms
  typedef struct packed {
    logic [13:0] freq;
    logic [15:0] dur;
  } tms_note_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic enter;
    logic note;
    logic snd_end;
    logic out_load;
  } tms_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exec_enter;
    logic exec_send;
    logic in_range;
    logic note_skip;
    logic rest_nz;
    logic out_free;
  } tms_stat_t;

  // Clamp a frequency to the supported range
  function automatic logic [13:0] clamp_freq(input logic [15:0] f);
    logic [15:0] c;
    begin
      if (f < FREQ_MIN) c = FREQ_MIN;
      else if (f > FREQ_MAX) c = FREQ_MAX;
      else c = f;
      return c[13:0];
    end
  endfunction

  // Sounding part of a note: drop the trailing rest on longer notes
  function automatic logic [15:0] sound_len(input logic [15:0] dur);
    begin
      return (dur > SHORT_NOTE_MS) ? (dur - REST_MS) : dur;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tms_regs.sv =====
`default_nettype none
module tms_regs
  import tms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic             loop_enable,
  output logic [15:0]      pass_gap_ms,
  output logic [6:0]       note_count
);

  logic        loop_en_r;
  logic [15:0] loop_gap_r;
  logic [6:0]  note_cnt_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Write registers in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_en_r  <= 1'b0;
      loop_gap_r <= LOOP_GAP_RST;
      note_cnt_r <= 7'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOOP_EN:  loop_en_r  <= cfg_pwdata[0];
        REG_LOOP_GAP: loop_gap_r <= cfg_pwdata[15:0];
        REG_NOTE_CNT: note_cnt_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_LOOP_EN:  cfg_prdata = {31'd0, loop_en_r};
      REG_LOOP_GAP: cfg_prdata = {16'd0, loop_gap_r};
      REG_NOTE_CNT: cfg_prdata = {25'd0, note_cnt_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign loop_enable = loop_en_r;
  assign pass_gap_ms = loop_gap_r;
  assign note_count  = note_cnt_r;

endmodule
`default_nettype wire

// ===== rtl/tms_ctrl.sv =====
`default_nettype none
module tms_ctrl
  import tms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire tms_stat_t stat,
  output tms_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_ENTER   = 3'd2;
  localparam logic [2:0] ST_NOTE    = 3'd3;
  localparam logic [2:0] ST_SND_END = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Sequence one item through execute, note walk and result hand-off
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (stat.exec_send) state_nxt = ST_SND_END;
        else if (stat.exec_enter) state_nxt = ST_ENTER;
        else state_nxt = ST_FIN;
      end
      ST_ENTER:   state_nxt = stat.in_range ? ST_NOTE : ST_FIN;
      ST_NOTE:    state_nxt = stat.note_skip ? ST_ENTER : ST_FIN;
      ST_SND_END: state_nxt = stat.rest_nz ? ST_FIN : ST_ENTER;
      ST_FIN:     if (stat.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands
  assign in_tready    = (state_r == ST_IDLE);
  assign cmd.accept   = (state_r == ST_IDLE) & in_tvalid;
  assign cmd.exec     = (state_r == ST_EXEC);
  assign cmd.enter    = (state_r == ST_ENTER);
  assign cmd.note     = (state_r == ST_NOTE);
  assign cmd.snd_end  = (state_r == ST_SND_END);
  assign cmd.out_load = (state_r == ST_FIN) & stat.out_free;

endmodule
`default_nettype wire

// ===== rtl/tms_dp.sv =====
`default_nettype none
module tms_dp
  import tms_pkg::*;
#(
  parameter int NOTE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tms_cmd_t    cmd,
  output tms_stat_t        stat,
  input  wire logic [2:0]  in_op,
  input  wire logic [5:0]  in_note_index,
  input  wire logic [15:0] in_note_freq,
  input  wire logic [15:0] in_note_dur,
  input  wire logic        loop_enable,
  input  wire logic [15:0] pass_gap_ms,
  input  wire logic [6:0]  note_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tone_on,
  output logic [13:0]      out_tone_freq,
  output logic             out_busy_res,
  output logic             out_play_done
);

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int CW = $clog2(NOTE_DEPTH + 1);

  tms_note_t   mem [NOTE_DEPTH];
  tms_note_t   rd_r;

  // Latched input beat
  logic [2:0]  op_r;
  logic [5:0]  idx_r;
  logic [15:0] freq_r;
  logic [15:0] dur_r;

  // Playback state
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic [15:0]   ms_r, ms_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          tmode_r, tmode_nxt;
  logic          busy_r, busy_nxt;
  logic [13:0]   cfreq_r, cfreq_nxt;
  logic          done_r, done_nxt;

  // Result register
  logic          oval_r;
  logic          otone_r;
  logic [13:0]   ofreq_r;
  logic          obusy_r;
  logic          odone_r;

  logic [CW-1:0] eff_cnt;
  logic [15:0]   ms_dec;
  logic [15:0]   ton_dur;
  logic          tick_exp;
  logic          idx_ok;

  // Notes played: count limited to the memory depth
  assign eff_cnt = (32'(note_count) > 32'(NOTE_DEPTH)) ? CW'(NOTE_DEPTH) : CW'(note_count);
  assign ms_dec  = (ms_r != 16'd0) ? (ms_r - 16'd1) : ms_r;
  assign ton_dur = (dur_r > TONE_DUR_MAX) ? TONE_DUR_MAX : dur_r;
  assign idx_ok  = (32'(idx_r) < 32'(NOTE_DEPTH));
  assign tick_exp = (op_r == OP_TICK) && (phase_r != PH_IDLE) && (ms_dec == 16'd0);

  // Status to the controller
  assign stat.exec_send  = tick_exp && !tmode_r && (phase_r == PH_SOUND);
  assign stat.exec_enter = (tick_exp && !tmode_r &&
                            ((phase_r == PH_REST) || (phase_r == PH_GAP))) ||
                           ((op_r == OP_START_MEL) && !busy_r && (eff_cnt != '0));
  assign stat.in_range   = (pidx_r < eff_cnt);
  assign stat.note_skip  = (rd_r.dur == 16'd0);
  assign stat.rest_nz    = (rd_r.dur > SHORT_NOTE_MS);
  assign stat.out_free   = !oval_r || out_ready;

  // Next playback state per command
  always_comb begin
    pidx_nxt  = pidx_r;
    ms_nxt    = ms_r;
    phase_nxt = phase_r;
    tmode_nxt = tmode_r;
    busy_nxt  = busy_r;
    cfreq_nxt = cfreq_r;
    done_nxt  = done_r;

    if (cmd.accept) begin
      done_nxt = 1'b0;
    end

    if (cmd.exec) begin
      case (op_r)
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            ms_nxt = ms_dec;
            if (ms_dec == 16'd0) begin
              if (tmode_r) begin
                phase_nxt = PH_IDLE;
                busy_nxt  = 1'b0;
                done_nxt  = 1'b1;
              end else if (phase_r == PH_REST) begin
                pidx_nxt = pidx_r + CW'(1);
              end else if (phase_r == PH_GAP) begin
                pidx_nxt = '0;
              end
            end
          end
        end
        OP_START_MEL: begin
          if (!busy_r && (eff_cnt != '0)) begin
            busy_nxt  = 1'b1;
            tmode_nxt = 1'b0;
            pidx_nxt  = '0;
          end
        end
        OP_START_TON: begin
          if (!busy_r) begin
            cfreq_nxt = clamp_freq(freq_r);
            tmode_nxt = 1'b1;
            busy_nxt  = 1'b1;
            if (ton_dur == 16'd0) begin
              phase_nxt = PH_IDLE;
              busy_nxt  = 1'b0;
              ms_nxt    = 16'd0;
              done_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_SOUND;
              ms_nxt    = ton_dur;
            end
          end
        end
        OP_STOP: begin
          if (busy_r) begin
            phase_nxt = PH_IDLE;
            busy_nxt  = 1'b0;
            ms_nxt    = 16'd0;
            done_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Past the last note: start the gap or end playback
    if (cmd.enter && !stat.in_range) begin
      if (loop_enable) begin
        phase_nxt = PH_GAP;
        ms_nxt    = pass_gap_ms;
      end else begin
        phase_nxt = PH_IDLE;
        busy_nxt  = 1'b0;
        ms_nxt    = 16'd0;
        done_nxt  = 1'b1;
      end
    end

    // Take the fetched note, skip it when its length is zero
    if (cmd.note) begin
      cfreq_nxt = rd_r.freq;
      if (rd_r.dur != 16'd0) begin
        phase_nxt = PH_SOUND;
        ms_nxt    = sound_len(rd_r.dur);
      end else begin
        pidx_nxt = pidx_r + CW'(1);
      end
    end

    // End of the sounding part: rest or move on
    if (cmd.snd_end) begin
      if (stat.rest_nz) begin
        phase_nxt = PH_REST;
        ms_nxt    = REST_MS;
      end else begin
        pidx_nxt = pidx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r  <= '0;
      ms_r    <= 16'd0;
      phase_r <= PH_IDLE;
      tmode_r <= 1'b0;
      busy_r  <= 1'b0;
      cfreq_r <= FREQ_MIN[13:0];
      done_r  <= 1'b0;
    end else begin
      pidx_r  <= pidx_nxt;
      ms_r    <= ms_nxt;
      phase_r <= phase_nxt;
      tmode_r <= tmode_nxt;
      busy_r  <= busy_nxt;
      cfreq_r <= cfreq_nxt;
      done_r  <= done_nxt;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      idx_r  <= in_note_index;
      freq_r <= in_note_freq;
      dur_r  <= in_note_dur;
    end
  end

  // Note memory: one write port, registered read at the play index
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == OP_LOAD) && idx_ok) begin
      mem[AW'(idx_r)] <= '{freq: clamp_freq(freq_r), dur: dur_r};
    end
    rd_r <= mem[pidx_r[AW-1:0]];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.out_load) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      otone_r <= (phase_r == PH_SOUND);
      ofreq_r <= cfreq_r;
      obusy_r <= busy_r;
      odone_r <= done_r;
    end
  end

  assign out_valid     = oval_r;
  assign out_tone_on   = otone_r;
  assign out_tone_freq = ofreq_r;
  assign out_busy_res  = obusy_r;
  assign out_play_done = odone_r;

endmodule
`default_nettype wire

// ===== rtl/tone_melody_sequencer.sv =====
// Path: an accepted input beat passes through the execute state, then the enter and note
// states for each note entered or skipped, the end-of-sound check and the end-of-pass
// check, to the final state that loads the result register; a stalled result waits there.
// Flow: one beat at a time; the next beat is taken the cycle after the result
// is loaded.
// Reset: synchronous active-low rst_n; idle, silent, 50 Hz selected, gap 3000 ms.
`default_nettype none
module tone_melody_sequencer
  import tms_pkg::*;
#(
  parameter int NOTE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: note_index[5:0], note_freq[21:6], note_dur[37:22], zero pad [39:38]
  input  wire logic [39:0] in_tdata,
  // in_tuser: op[2:0]
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: tone_on[0], tone_freq[14:1], busy_res[15]
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  tms_cmd_t    cmd;
  tms_stat_t   stat;
  logic        loop_enable;
  logic [15:0] pass_gap_ms;
  logic [6:0]  note_count;
  logic        tone_on;
  logic [13:0] tone_freq;
  logic        busy_res;

  tms_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .loop_enable (loop_enable),
    .pass_gap_ms (pass_gap_ms),
    .note_count  (note_count)
  );

  tms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tms_dp #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_tuser),
    .in_note_index (in_tdata[5:0]),
    .in_note_freq  (in_tdata[21:6]),
    .in_note_dur   (in_tdata[37:22]),
    .loop_enable   (loop_enable),
    .pass_gap_ms   (pass_gap_ms),
    .note_count    (note_count),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_tone_on   (tone_on),
    .out_tone_freq (tone_freq),
    .out_busy_res  (busy_res),
    .out_play_done (out_tlast)
  );

  assign out_tdata = {busy_res, tone_freq, tone_on};

endmodule
`default_nettype wire

// ===== sim/tb_tone_melody_sequencer.sv =====
module tb_tone_melody_sequencer;
  import tms_pkg::*;

  localparam logic [6:0] NOTE_SLOTS   = 7'd64;
  localparam logic [2:0] OP_BAD_FIRST = OP_STOP + 3'd1;
  localparam logic [2:0] OP_BAD_LAST  = 3'b111;
  localparam int         ITEMS        = 1400;
  localparam int         PHASE_ITEMS  = 140;
  localparam int         HOLD_CYCLES  = 2 * 64 + 12;

  // One input beat and one result beat
  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [15:0] hz;
    logic [15:0] ms;
  } beat_t;

  typedef struct packed {
    logic        tone_on;
    logic [13:0] hz;
    logic        busy;
    logic        done;
  } tune_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tone_melody_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer copy: note memory, playback state and live registers
  logic [13:0] note_hz [0:63];
  logic [15:0] note_ms [0:63];
  logic [6:0]  seq_pos;
  logic [15:0] seq_ms;
  logic [1:0]  seq_phase;
  logic        seq_tone;
  logic        seq_busy;
  logic [13:0] seq_freq;
  logic        done_now;
  logic        loop_on;
  logic [15:0] gap_ms;
  logic [6:0]  count_reg;

  // Stimulus side mirror of the note memory, so no unwritten slot is played
  bit          slot_set [0:63];
  logic [15:0] slot_ms [0:63];

  beat_t stim_q [$];
  tune_t tune_q [$];
  beat_t send_beat;
  int    n_queued, n_taken, n_checked, n_ends, n_repeats, n_settings, mismatch_cnt;
  int    send_wait, recv_wait;
  bit    send_steady, recv_steady;
  logic  in_fire = 1'b0;
  logic  out_fire = 1'b0;

  function automatic logic [13:0] clamp_hz(input logic [15:0] f);
    logic [15:0] c;
    c = f;
    if (f < FREQ_MIN) c = FREQ_MIN;
    if (f > FREQ_MAX) c = FREQ_MAX;
    return c[13:0];
  endfunction

  // Sounding part of a note; longer notes keep a silent tail
  function automatic logic [15:0] on_ms(input logic [15:0] d);
    return (d > SHORT_NOTE_MS) ? d - REST_MS : d;
  endfunction

  function automatic int eff_slots();
    return (count_reg > NOTE_SLOTS) ? int'(NOTE_SLOTS) : int'(count_reg);
  endfunction

  task automatic end_play();
    seq_phase = PH_IDLE;
    seq_busy  = 1'b0;
    seq_ms    = '0;
    done_now  = 1'b1;
  endtask

  // Enter the note at seq_pos, skipping zero-length notes; close the pass at the end
  task automatic next_note();
    int lim;
    bit found;
    lim   = eff_slots();
    found = 1'b0;
    while (!found && seq_pos < lim) begin
      seq_freq = note_hz[seq_pos[5:0]];
      if (note_ms[seq_pos[5:0]] != 0) begin
        found     = 1'b1;
        seq_phase = PH_SOUND;
        seq_ms    = on_ms(note_ms[seq_pos[5:0]]);
      end else begin
        seq_pos++;
      end
    end
    if (!found) begin
      if (loop_on) begin
        seq_phase = PH_GAP;
        seq_ms    = gap_ms;
      end else begin
        end_play();
      end
    end
  endtask

  // Advance the sequencer by one beat and form its result
  task automatic tune_step(input beat_t b, output tune_t r);
    logic [15:0] len;
    logic [15:0] tail;
    logic [15:0] tone_len;
    done_now = 1'b0;
    case (b.op)
      OP_TICK: begin
        if (seq_phase != PH_IDLE) begin
          if (seq_ms != 0) seq_ms--;
          if (seq_ms == 0) begin
            if (seq_tone) begin
              end_play();
            end else if (seq_phase == PH_SOUND) begin
              len  = (seq_pos < NOTE_SLOTS) ? note_ms[seq_pos[5:0]] : 16'd0;
              tail = len - on_ms(len);
              if (tail != 0) begin
                seq_phase = PH_REST;
                seq_ms    = tail;
              end else begin
                seq_pos++;
                next_note();
              end
            end else if (seq_phase == PH_REST) begin
              seq_pos++;
              next_note();
            end else begin
              seq_pos = '0;
              n_repeats++;
              next_note();
            end
          end
        end
      end
      OP_LOAD: begin
        note_hz[b.slot] = clamp_hz(b.hz);
        note_ms[b.slot] = b.ms;
      end
      OP_START_MEL: begin
        if (!seq_busy && count_reg != 0) begin
          seq_busy = 1'b1;
          seq_tone = 1'b0;
          seq_pos  = '0;
          next_note();
        end
      end
      OP_START_TON: begin
        if (!seq_busy) begin
          seq_freq = clamp_hz(b.hz);
          seq_tone = 1'b1;
          seq_busy = 1'b1;
          tone_len = (b.ms > TONE_DUR_MAX) ? TONE_DUR_MAX : b.ms;
          if (tone_len == 0) begin
            end_play();
          end else begin
            seq_phase = PH_SOUND;
            seq_ms    = tone_len;
          end
        end
      end
      OP_STOP: begin
        if (seq_busy) end_play();
      end
      default: ;
    endcase
    r.tone_on = (seq_phase == PH_SOUND);
    r.hz      = seq_freq;
    r.busy    = seq_busy;
    r.done    = done_now;
    if (done_now) n_ends++;
  endtask

  // Queue one beat and track note loads in the mirror
  task automatic put(input logic [2:0] op, input logic [5:0] slot,
                     input logic [15:0] hz, input logic [15:0] ms);
    beat_t b;
    b.op   = op;
    b.slot = slot;
    b.hz   = hz;
    b.ms   = ms;
    stim_q.push_back(b);
    n_queued++;
    if (op == OP_LOAD) begin
      slot_set[slot] = 1'b1;
      slot_ms[slot]  = ms;
    end
  endtask

  function automatic logic [15:0] pick_hz();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return FREQ_MIN - 16'd1;
      2:       return FREQ_MIN;
      3:       return FREQ_MAX;
      4:       return FREQ_MAX + 16'd1;
      5:       return 16'hFFFF;
      6, 7:    return $urandom;
      default: return $urandom_range(FREQ_MIN, FREQ_MAX);
    endcase
  endfunction

  function automatic logic [15:0] note_len();
    case ($urandom_range(0, 29))
      0, 1:    return 16'd0;
      2:       return SHORT_NOTE_MS;
      3:       return SHORT_NOTE_MS + 16'd1;
      4:       return 16'd1;
      5:       return $urandom;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic bit melody_ready();
    bit ok;
    ok = 1'b1;
    for (int i = 0; i < eff_slots(); i++)
      if (!slot_set[i]) ok = 1'b0;
    return ok;
  endfunction

  task automatic put_noise();
    case ($urandom_range(0, 5))
      0: put(OP_STOP, $urandom, $urandom, $urandom);
      1: put(OP_START_TON, $urandom, pick_hz(), $urandom_range(0, 40));
      2: begin
        if (melody_ready()) put(OP_START_MEL, $urandom, $urandom, $urandom);
        else put(OP_TICK, $urandom, $urandom, $urandom);
      end
      3: put(OP_LOAD, $urandom, pick_hz(), note_len());
      4: put($urandom_range(OP_BAD_FIRST, OP_BAD_LAST), $urandom, $urandom, $urandom);
      default: put(OP_TICK, $urandom, $urandom, $urandom);
    endcase
  endtask

  task automatic put_ticks(input int k);
    repeat (k) begin
      if ($urandom_range(0, 14) == 0) put_noise();
      else put(OP_TICK, $urandom, $urandom, $urandom);
    end
  endtask

  // Hold until every queued beat is taken and every result has come back
  task automatic settle();
    while (stim_q.size() != 0 || n_taken != n_queued || tune_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (reg_idx)
      REG_LOOP_EN:  loop_on   = val[0];
      REG_LOOP_GAP: gap_ms    = val[15:0];
      REG_NOTE_CNT: count_reg = val[6:0];
      default: ;
    endcase
  endtask

  // Reprogram all registers once the sequencer has gone quiet
  task automatic set_regs(input logic lp, input logic [15:0] gap, input logic [6:0] cnt);
    settle();
    repeat (HOLD_CYCLES) @(posedge clk);
    write_reg(REG_LOOP_EN, {31'd0, lp});
    write_reg(REG_LOOP_GAP, {16'd0, gap});
    write_reg(REG_NOTE_CNT, {25'd0, cnt});
    n_settings++;
  endtask

  // Feed queued beats, with a random wait before each one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_tvalid) begin
        if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
        send_wait = send_steady ? 0 : $urandom_range(0, 9);
      end
      if (send_wait != 0 || stim_q.size() == 0) begin
        if (send_wait != 0) send_wait--;
        in_tvalid <= 1'b0;
      end else begin
        send_beat = stim_q.pop_front();
        in_tuser  <= send_beat.op;
        in_tdata  <= {2'b00, send_beat.ms, send_beat.hz, send_beat.slot};
        in_tvalid <= 1'b1;
      end
    end
  end

  // Stall the result side for a random number of cycles per beat
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!out_tready || out_fire) begin
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) recv_steady = !recv_steady;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 9);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Predict on every input beat taken, check every result beat taken
  always @(posedge clk) begin : watch_beats
    beat_t b;
    tune_t want;
    tune_t got;
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      b.op   = in_tuser;
      b.slot = in_tdata[5:0];
      b.hz   = in_tdata[21:6];
      b.ms   = in_tdata[37:22];
      tune_step(b, want);
      tune_q.push_back(want);
      n_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.tone_on = out_tdata[0];
      got.hz      = out_tdata[14:1];
      got.busy    = out_tdata[15];
      got.done    = out_tlast;
      if (tune_q.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_cnt++;
      end else begin
        want = tune_q.pop_front();
        n_checked++;
        if (got.tone_on !== want.tone_on) begin
          $error("tone_on: expected %0d, got %0d", want.tone_on, got.tone_on);
          mismatch_cnt++;
        end
        if (got.hz !== want.hz) begin
          $error("tone_freq: expected %0d, got %0d", want.hz, got.hz);
          mismatch_cnt++;
        end
        if (got.busy !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
          mismatch_cnt++;
        end
        if (got.done !== want.done) begin
          $error("play_done: expected %0d, got %0d", want.done, got.done);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          k;
    int          start_n;
    int          phase_no;
    int          span;
    logic [15:0] ms;
    for (int i = 0; i < 64; i++) begin
      note_hz[i] = '0;
      note_ms[i] = '0;
    end
    seq_pos   = '0;
    seq_ms    = '0;
    seq_phase = PH_IDLE;
    seq_tone  = 1'b0;
    seq_busy  = 1'b0;
    seq_freq  = FREQ_MIN[13:0];
    loop_on   = 1'b0;
    gap_ms    = LOOP_GAP_RST;
    count_reg = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle no-ops, empty melody, unknown ops, tone clamps and stops
    put(OP_TICK, 0, 0, 0);
    put(OP_STOP, '1, '1, '1);
    put(OP_START_MEL, 0, 0, 0);
    put(OP_BAD_FIRST, '1, '1, '1);
    put(OP_BAD_LAST, 0, 0, 0);
    put(OP_START_TON, 0, 16'd0, 16'd0);
    put(OP_START_TON, 0, 16'hFFFF, 16'hFFFF);
    put(OP_START_TON, 0, 16'd1234, 16'd5);
    put(OP_START_MEL, 0, 0, 0);
    put(OP_TICK, 0, 0, 0);
    put(OP_TICK, '1, '1, '1);
    put(OP_STOP, 0, 0, 0);
    put(OP_START_TON, 0, FREQ_MAX, 16'd1);
    put(OP_TICK, 0, 0, 0);
    put(OP_START_TON, 0, FREQ_MAX + 16'd1, TONE_DUR_MAX + 16'd1);
    put(OP_STOP, 0, 0, 0);
    put(OP_LOAD, 6'd63, 16'hFFFF, 16'hFFFF);
    put(OP_LOAD, 6'd0, 16'd0, 16'd0);
    put(OP_LOAD, 6'd1, FREQ_MIN - 16'd1, SHORT_NOTE_MS + 16'd1);
    put(OP_LOAD, 6'd2, FREQ_MAX + 16'd1, SHORT_NOTE_MS);
    put(OP_LOAD, 6'd3, FREQ_MIN, 16'd1);

    // Looping melody with a zero gap, a busy restart, a live rewrite, then stop
    set_regs(1'b1, 16'd0, 7'd4);
    put(OP_START_MEL, 0, 0, 0);
    repeat (30) put(OP_TICK, 0, 0, 0);
    put(OP_START_MEL, 0, 0, 0);
    put(OP_LOAD, 6'd1, 16'd440, 16'd30);
    repeat (3) put(OP_TICK, 0, 0, 0);
    put(OP_STOP, 0, 0, 0);

    // Pass of zero-length notes only, no loop: ends on its start beat
    set_regs(1'b0, 16'd5, 7'd1);
    put(OP_START_MEL, 0, 0, 0);

    // Random phases, each under its own register setting
    phase_no = 0;
    while (n_queued < ITEMS) begin
      case (phase_no)
        0:       set_regs(1'b1, 16'd0, NOTE_SLOTS);
        1:       set_regs(1'b1, 16'hFFFF, 7'd1);
        2:       set_regs(1'b1, 16'd1, 7'd3);
        3:       set_regs(1'b0, 16'd2, 7'h7F);
        default: set_regs($urandom_range(0, 1), $urandom_range(0, 20), $urandom_range(1, 6));
      endcase
      start_n = n_queued;
      while (n_queued - start_n < PHASE_ITEMS && n_queued < ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Fill missing slots, maybe rewrite some, start and run the melody
          for (int i = 0; i < eff_slots(); i++)
            if (!slot_set[i]) put(OP_LOAD, i, pick_hz(), note_len());
          repeat ($urandom_range(0, 2)) put(OP_LOAD, $urandom, pick_hz(), note_len());
          put(OP_START_MEL, $urandom, $urandom, $urandom);
          if ($urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, 60);
          end else begin
            span = 0;
            for (int i = 0; i < eff_slots(); i++)
              span += (slot_ms[i] > 100) ? 100 : int'(slot_ms[i]);
            if (loop_on) span += (gap_ms > 40) ? 40 : int'(gap_ms);
            k = span + $urandom_range(0, 8);
            if (k > 300) k = 300;
          end
          put_ticks(k);
        end else if (pick < 80) begin
          case ($urandom_range(0, 9))
            0:       ms = 16'd0;
            1:       ms = TONE_DUR_MAX;
            2:       ms = TONE_DUR_MAX + 16'd1;
            3:       ms = 16'hFFFF;
            4:       ms = $urandom;
            default: ms = $urandom_range(1, 40);
          endcase
          put(OP_START_TON, $urandom, pick_hz(), ms);
          put_ticks($urandom_range(0, 50));
        end else begin
          repeat ($urandom_range(1, 6)) put_noise();
        end
        if ($urandom_range(0, 2) == 0) put(OP_STOP, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 24) == 0) settle();
      end
      phase_no++;
    end

    settle();
    repeat (HOLD_CYCLES) @(posedge clk);
    $display("Covered %0d input beats and %0d result beats under %0d register settings;",
             n_taken, n_checked, n_settings);
    $display("%0d playbacks ended and %0d melody repeats began.", n_ends, n_repeats);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tms_pkg.sv
rtl/tms_regs.sv
rtl/tms_ctrl.sv
rtl/tms_dp.sv
rtl/tone_melody_sequencer.sv
sim/tb_tone_melody_sequencer.sv
